@@ rtl/bitmap_font_text_renderer_unit_assert.svh @@
`ifndef BITMAP_FONT_TEXT_RENDERER_UNIT_ASSERT_SVH
`define BITMAP_FONT_TEXT_RENDERER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define BFTR_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, sampled on clk, off during rst
`define BFTR_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ rtl/bftr_pkg.sv @@
`timescale 1ns / 1ps

package bftr_pkg;

  localparam int FONT_BYTES       = 16384;
  localparam int MAX_GLYPH_HEIGHT = 32;
  localparam int MAX_TEXT_ROWS    = 256;

  localparam int FONT_ADDR_W = $clog2(FONT_BYTES);
  localparam int ROW_W       = $clog2(MAX_TEXT_ROWS);
  localparam int H_LIMIT     = (MAX_GLYPH_HEIGHT < 32) ? MAX_GLYPH_HEIGHT : 32;
  // glyph index (10) + bytes per glyph (8) + row/byte offset headroom
  localparam int PTR_W       = 19;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] NEWLINE_CODE = 16'd10;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_PUT   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_WIDTH      = 3'd0,
    CFG_GLYPH_HEIGHT     = 3'd1,
    CFG_GLYPH_COUNT      = 3'd2,
    CFG_BYTES_PER_GLYPH  = 3'd3,
    CFG_SCANLINE_BYTES   = 3'd4,
    CFG_COLUMNS_PER_LINE = 3'd5
  } cfg_idx_t;

  localparam logic [5:0]  RST_GLYPH_WIDTH      = 6'd8;
  localparam logic [5:0]  RST_GLYPH_HEIGHT     = 6'd16;
  localparam logic [9:0]  RST_GLYPH_COUNT      = 10'd256;
  localparam logic [7:0]  RST_BYTES_PER_GLYPH  = 8'd16;
  localparam logic [15:0] RST_SCANLINE_BYTES   = 16'd4096;
  localparam logic [9:0]  RST_COLUMNS_PER_LINE = 10'd113;

  typedef struct packed {
    logic load;     // font byte write on this transaction
    logic put;      // capture character code
    logic clear;    // cursor to origin
    logic prep;     // newline / wrap, latch glyph geometry
    logic mul1;     // row*h and column*(w+1)
    logic mul2;     // start offset and glyph base address
    logic fetch;    // issue one font byte read
    logic emit;     // load output register with a finished row
    logic advance;  // step the cursor after the last row
  } cmd_t;

  typedef struct packed {
    logic newline;
    logic wrap;
    logic last_byte;
    logic last_row;
    logic out_free;
  } status_t;

endpackage

@@ rtl/bftr_ram.sv @@
`timescale 1ns / 1ps

module bftr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bftr_ctrl.sv @@
`timescale 1ns / 1ps
`include "bitmap_font_text_renderer_unit_assert.svh"

module bftr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [1:0]        s_axis_tuser,
  output bftr_pkg::cmd_t    cmd,
  input  bftr_pkg::status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL1,
    S_MUL2,
    S_FETCH,
    S_LAST
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load  = accept && (s_axis_tuser == bftr_pkg::ACT_LOAD);
        cmd.put   = accept && (s_axis_tuser == bftr_pkg::ACT_PUT);
        cmd.clear = accept && (s_axis_tuser == bftr_pkg::ACT_CLEAR);
        if (cmd.put) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.newline ? S_IDLE : S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (status.last_byte) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        // last byte of the row sits in the ram output until the row leaves
        cmd.emit    = status.out_free;
        cmd.advance = status.out_free && status.last_row;
        if (status.out_free) begin
          state_next = status.last_row ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `BFTR_CHK_NOW(a_emit_needs_room, cmd.emit, status.out_free)
  `BFTR_CHK_NOW(a_advance_on_last, cmd.advance, cmd.emit && status.last_row)
  `BFTR_CHK_NEXT(a_fetch_ends_row, (state == S_FETCH) && status.last_byte, state == S_LAST)
  `BFTR_CHK_NEXT(a_put_starts_prep, cmd.put, state == S_PREP)

endmodule

@@ rtl/bftr_dp.sv @@
`timescale 1ns / 1ps

module bftr_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  bftr_pkg::cmd_t                      cmd,
  output bftr_pkg::status_t                   status,
  input  logic [bftr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                cfg_we,
  input  logic [bftr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bftr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bftr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast
);

  localparam int AW    = bftr_pkg::FONT_ADDR_W;
  localparam int RW    = bftr_pkg::ROW_W;
  localparam int PW    = bftr_pkg::PTR_W;
  localparam int PRH_W = bftr_pkg::ROW_W + 6;

  logic [15:0] in_code;
  logic [13:0] in_addr;
  logic [7:0]  in_byte;

  logic [5:0]  glyph_width;
  logic [5:0]  glyph_height;
  logic [9:0]  glyph_count;
  logic [7:0]  bytes_per_glyph;
  logic [15:0] scanline_bytes;
  logic [9:0]  columns_per_line;

  logic [9:0]    cursor_col;
  logic [RW-1:0] cursor_row;

  logic [15:0]      code;
  logic [5:0]       w;
  logic [5:0]       h;
  logic [2:0]       bpl;
  logic [2:0]       shamt;
  logic [9:0]       g;
  logic [PRH_W-1:0] p_rh;
  logic [15:0]      p_cw;
  logic [31:0]      row_off;
  logic [PW-1:0]    ptr;
  logic [1:0]       k;
  logic [4:0]       r;
  logic [31:0]      bits;
  logic             rd_valid;
  logic             rd_oob;
  logic [7:0]       rd_data;
  logic [7:0]       rd_byte;

  logic             out_valid;
  logic [31:0]      out_offset;
  logic [31:0]      out_mask;
  logic             out_last;

  logic [5:0]  w_sat;
  logic [5:0]  h_min;
  logic [5:0]  h_sat;
  logic [2:0]  bpl_calc;
  logic [2:0]  shamt_calc;
  logic [9:0]  g_calc;
  logic [9:0]  cells;
  logic [9:0]  col_inc;
  logic        row_at_max;
  logic [31:0] full;
  logic [31:0] mask_now;
  logic        ram_we;

  assign in_code = s_axis_tdata[15:0];
  assign in_addr = s_axis_tdata[29:16];
  assign in_byte = s_axis_tdata[37:30];

  assign w_sat = (glyph_width == 6'd0) ? 6'd1 :
                 ((glyph_width > 6'd32) ? 6'd32 : glyph_width);
  assign h_min = (glyph_height == 6'd0) ? 6'd1 : glyph_height;
  assign h_sat = (h_min > 6'(bftr_pkg::H_LIMIT)) ? 6'(bftr_pkg::H_LIMIT) : h_min;
  assign bpl_calc   = 3'((w_sat + 6'd7) >> 3);
  // pad bits to drop on the right of the big-endian row word
  assign shamt_calc = 3'({bpl_calc, 3'b000} - w_sat);
  assign g_calc = ((code != 16'd0) && (code < 16'(glyph_count))) ? code[9:0] : 10'd0;

  assign cells      = (columns_per_line == 10'd0) ? 10'd1 : columns_per_line;
  assign col_inc    = cursor_col + 10'd1;
  assign row_at_max = (cursor_row == RW'(bftr_pkg::MAX_TEXT_ROWS - 1));

  assign rd_byte  = rd_oob ? 8'd0 : rd_data;
  assign full     = {bits[23:0], rd_byte};
  assign mask_now = full >> shamt;

  assign status.newline   = (code == bftr_pkg::NEWLINE_CODE);
  assign status.wrap      = (cursor_col >= cells);
  assign status.last_byte = ({1'b0, k} == (bpl - 3'd1));
  assign status.last_row  = ({1'b0, r} == (h - 6'd1));
  assign status.out_free  = !out_valid || m_axis_tready;

  assign ram_we = cmd.load && (32'(in_addr) < bftr_pkg::FONT_BYTES);

  bftr_ram #(
    .WIDTH (8),
    .DEPTH (bftr_pkg::FONT_BYTES)
  ) u_font_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_addr)),
    .wdata (in_byte),
    .re    (cmd.fetch),
    .raddr (ptr[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width      <= bftr_pkg::RST_GLYPH_WIDTH;
      glyph_height     <= bftr_pkg::RST_GLYPH_HEIGHT;
      glyph_count      <= bftr_pkg::RST_GLYPH_COUNT;
      bytes_per_glyph  <= bftr_pkg::RST_BYTES_PER_GLYPH;
      scanline_bytes   <= bftr_pkg::RST_SCANLINE_BYTES;
      columns_per_line <= bftr_pkg::RST_COLUMNS_PER_LINE;
      cursor_col       <= '0;
      cursor_row       <= '0;
      rd_valid         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bftr_pkg::CFG_GLYPH_WIDTH:      glyph_width      <= cfg_data[5:0];
          bftr_pkg::CFG_GLYPH_HEIGHT:     glyph_height     <= cfg_data[5:0];
          bftr_pkg::CFG_GLYPH_COUNT:      glyph_count      <= cfg_data[9:0];
          bftr_pkg::CFG_BYTES_PER_GLYPH:  bytes_per_glyph  <= cfg_data[7:0];
          bftr_pkg::CFG_SCANLINE_BYTES:   scanline_bytes   <= cfg_data;
          bftr_pkg::CFG_COLUMNS_PER_LINE: columns_per_line <= cfg_data[9:0];
          default: begin
          end
        endcase
      end

      rd_valid <= cmd.fetch;

      if (cmd.clear) begin
        cursor_col <= '0;
        cursor_row <= '0;
      end else if (cmd.prep && (status.newline || status.wrap)) begin
        cursor_col <= '0;
        if (!row_at_max) begin
          cursor_row <= cursor_row + RW'(1);
        end
      end else if (cmd.advance) begin
        if (col_inc >= cells) begin
          cursor_col <= '0;
          if (!row_at_max) begin
            cursor_row <= cursor_row + RW'(1);
          end
        end else begin
          cursor_col <= col_inc;
        end
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      code <= in_code;
    end
    if (cmd.prep) begin
      w     <= w_sat;
      h     <= h_sat;
      bpl   <= bpl_calc;
      shamt <= shamt_calc;
      g     <= g_calc;
    end
    if (cmd.mul1) begin
      p_rh <= PRH_W'(cursor_row) * PRH_W'(h);
      p_cw <= 16'(cursor_col) * (16'(w) + 16'd1);
    end
    if (cmd.mul2) begin
      row_off <= 32'(p_rh) * 32'(scanline_bytes) + 32'({p_cw, 2'b00});
      ptr     <= PW'(g) * PW'(bytes_per_glyph);
      k       <= '0;
      r       <= '0;
      bits    <= '0;
    end
    if (cmd.fetch) begin
      rd_oob <= (32'(ptr) >= bftr_pkg::FONT_BYTES);
      ptr    <= ptr + PW'(1);
      k      <= k + 2'd1;
      if (rd_valid) begin
        bits <= full;
      end
    end
    if (cmd.emit) begin
      out_offset <= row_off;
      out_mask   <= mask_now;
      out_last   <= status.last_row;
      row_off    <= row_off + 32'(scanline_bytes);
      r          <= r + 5'd1;
      k          <= '0;
      bits       <= '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_mask, out_offset};
  assign m_axis_tlast  = out_last;

endmodule

@@ rtl/bitmap_font_text_renderer_unit.sv @@
`timescale 1ns / 1ps

// Text console glyph renderer. Input transactions carry an action in tuser:
// load one font byte, put a character, or clear the cursor. A put character
// produces one output transaction per glyph pixel row (row byte offset in the
// framebuffer and a pixel mask, leftmost pixel in the highest used bit), with
// tlast on the final row; newline only moves the cursor. A drawn character has
// h rows, where h is the glyph height and bpl = ceil(width/8): the font memory
// has a single byte-wide read port, so each row costs one read per byte plus a
// hand-over of the row to the output register, which waits on output stalls.
// The font memory has no reset; glyphs must be loaded before they are drawn.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
module bitmap_font_text_renderer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] char_code, [29:16] font_addr, [37:30] font_byte, [39:38] zero
  input  logic [bftr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] action
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] row_offset, [63:32] row_mask
  output logic [bftr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // last_row
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [bftr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bftr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bftr_pkg::cmd_t    cmd;
  bftr_pkg::status_t status;

  bftr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .cmd           (cmd),
    .status        (status)
  );

  bftr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
